/* design/fmrc_pkg.sv */
// Shared types, constants and match helper for the first-match rule classifier.
`default_nettype none
package fmrc_pkg;

  // Default sizing
  localparam int MAX_RULES_DEF   = 64;
  localparam int VALUE_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int CNT_W   = 7;   // rule_count register
  localparam int IDX_W   = 6;   // entry_index field
  localparam int FIELD_W = 16;  // slot depth, pool size, rule id ports

  // Opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // Register indexes
  localparam logic REG_RULE_COUNT  = 1'b0;
  localparam logic REG_FABRIC_KIND = 1'b1;

  // Dynamic class codes
  localparam logic [1:0] PEER_DYN = 2'd2;
  localparam logic [1:0] SIZE_DYN = 2'd3;
  localparam logic [1:0] FREQ_DYN = 2'd3;

  // Paths
  localparam logic [1:0] PATH_NATIVE = 2'd0;
  localparam logic [1:0] PATH_PROXY  = 2'd2;

  // Fallback decision
  localparam logic [FIELD_W-1:0] FALLBACK_POOL = 16'd16;
  localparam logic [FIELD_W-1:0] FALLBACK_ID   = 16'hFFFE;  // -2

  typedef struct packed {
    logic [1:0] peer;
    logic [1:0] size;
    logic [1:0] freq;
  } key_t;

  typedef struct packed {
    logic [1:0]         path;
    logic [FIELD_W-1:0] slots;
    logic [FIELD_W-1:0] pool;
    logic               chmap;
    logic               conservative;
    logic [FIELD_W-1:0] rule_id;
  } decision_t;

  // Rule as presented by a write item
  typedef struct packed {
    key_t       pred;
    logic [2:0] mask;
    decision_t  dec;
  } rule_t;

  // Lookup in flight, handed from cell to cell
  typedef struct packed {
    logic      valid;
    key_t      key;
    logic      found;
    decision_t dec;
  } token_t;

  function automatic logic pred_ok(input logic present, input logic [1:0] pred,
                                   input logic [1:0] feat, input logic [1:0] dyn);
    pred_ok = !present || (feat == dyn) || (pred == feat);
  endfunction

endpackage
`default_nettype wire

/* design/fmrc_cell.sv */
// One rule cell: holds a rule and resolves a passing lookup against it.
`default_nettype none
module fmrc_cell #(
  parameter int INDEX       = 0,
  parameter int VALUE_WIDTH = fmrc_pkg::VALUE_WIDTH_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           wr_en,
  input  wire [fmrc_pkg::IDX_W-1:0]     wr_index,
  input  fmrc_pkg::rule_t               wr_rule,
  input  wire [fmrc_pkg::CNT_W-1:0]     rule_count,
  input  fmrc_pkg::token_t              tok_in,
  output fmrc_pkg::token_t              tok_out
);

  localparam int  STORE_W = (VALUE_WIDTH < fmrc_pkg::FIELD_W) ? VALUE_WIDTH
                                                               : fmrc_pkg::FIELD_W;
  localparam bit  WR_FIT  = INDEX < (2 ** fmrc_pkg::IDX_W);
  localparam bit  CNT_FIT = INDEX < (2 ** fmrc_pkg::CNT_W);

  // stored rule
  fmrc_pkg::key_t                pred;
  logic [2:0]                    mask;
  logic [1:0]                    path;
  logic [STORE_W-1:0]            slots;
  logic [STORE_W-1:0]            pool;
  logic                          chmap;
  logic                          conservative;
  logic [fmrc_pkg::FIELD_W-1:0]  rule_id;

  logic                          wr_hit;
  logic                          active;
  logic                          hit;
  fmrc_pkg::decision_t           own_dec;

  assign wr_hit = WR_FIT && wr_en && (wr_index == fmrc_pkg::IDX_W'(INDEX));
  assign active = CNT_FIT && (rule_count > fmrc_pkg::CNT_W'(INDEX));

  assign hit = active &&
               fmrc_pkg::pred_ok(mask[0], pred.peer, tok_in.key.peer, fmrc_pkg::PEER_DYN) &&
               fmrc_pkg::pred_ok(mask[1], pred.size, tok_in.key.size, fmrc_pkg::SIZE_DYN) &&
               fmrc_pkg::pred_ok(mask[2], pred.freq, tok_in.key.freq, fmrc_pkg::FREQ_DYN);

  always_comb begin
    own_dec.path         = path;
    own_dec.slots        = fmrc_pkg::FIELD_W'(slots);
    own_dec.pool         = fmrc_pkg::FIELD_W'(pool);
    own_dec.chmap        = chmap;
    own_dec.conservative = conservative;
    own_dec.rule_id      = rule_id;
  end

  // rule storage
  always_ff @(posedge clk) begin
    if (wr_hit) begin
      pred         <= wr_rule.pred;
      mask         <= wr_rule.mask;
      path         <= wr_rule.dec.path;
      slots        <= wr_rule.dec.slots[STORE_W-1:0];
      pool         <= wr_rule.dec.pool[STORE_W-1:0];
      chmap        <= wr_rule.dec.chmap;
      conservative <= wr_rule.dec.conservative;
      rule_id      <= wr_rule.dec.rule_id;
    end
  end

  // lookup stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.key <= tok_in.key;
    if (!tok_in.found && hit) begin
      tok_out.found <= 1'b1;
      tok_out.dec   <= own_dec;
    end else begin
      tok_out.found <= tok_in.found;
      tok_out.dec   <= tok_in.dec;
    end
  end

endmodule
`default_nettype wire

/* design/first_match_rule_classifier.sv */
// Top level of the first-match rule classifier: command port, register file, cell chain.
//
// The rule table lives in a chain of MAX_RULES cells, one rule per cell, in table
// order. A write item (opcode 0) stores one rule in the cell named by entry_index
// and gives no result; indexes at or past MAX_RULES are dropped. An evaluate item
// (opcode 1) enters the head of the chain and moves one cell per clock; the first
// active cell (index below rule_count) whose predicates all match stamps its
// decision onto the item, later cells pass it on untouched. The decision leaves the
// chain into the output registers, where done pulses for one cycle; whatever
// rule_count is, the chain length sets the latency. For an evaluate, busy stays
// high from the accepting edge until done, and start is taken again in the cycle
// done is shown, so no new item is taken while an evaluate is in the chain; writes
// are taken back to back while busy is low. If no rule matches the result is the
// fallback: path native (fabric_kind 0) or proxy (fabric_kind 1), slot depth 0,
// pool 16, channel map 0, conservative set, rule id -2. The result cannot be
// stalled; the receiver must take it in the done cycle. Rules below rule_count
// must have been written since reset before an evaluate. Registers: rule_count at
// byte address 0, fabric_kind at 4; write them only while busy is low.
`default_nettype none
module first_match_rule_classifier #(
  parameter int MAX_RULES   = fmrc_pkg::MAX_RULES_DEF,
  parameter int VALUE_WIDTH = fmrc_pkg::VALUE_WIDTH_DEF
) (
  input  wire               clk,
  input  wire               rst,

  // command channel
  input  wire               start,
  output logic              busy,
  input  wire               opcode,
  input  wire [5:0]         entry_index,
  input  wire [1:0]         peer_value,
  input  wire [1:0]         size_value,
  input  wire [1:0]         freq_value,
  input  wire [2:0]         test_mask,
  input  wire [1:0]         path_in,
  input  wire [15:0]        slot_depth_in,
  input  wire [15:0]        pool_size_in,
  input  wire               channel_map_in,
  input  wire               conservative_in,
  input  wire signed [15:0] rule_id_in,

  // result channel
  output logic              done,
  output logic [1:0]        path_out,
  output logic [15:0]       slot_depth_out,
  output logic [15:0]       pool_size_out,
  output logic              channel_map_out,
  output logic              conservative_out,
  output logic signed [15:0] rule_id_out,

  // register port
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire [2:0]         paddr,
  input  wire [31:0]        pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // config registers
  logic [fmrc_pkg::CNT_W-1:0] rule_count;
  logic                       fabric_kind;

  logic                       cfg_wr;
  logic                       reg_sel;

  logic                       accept;
  logic                       wr_en;
  logic                       eval_en;
  logic                       busy_next;

  fmrc_pkg::rule_t            wr_rule;
  fmrc_pkg::token_t           chain [0:MAX_RULES];
  fmrc_pkg::token_t           tail;

  // ---------------- register port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_count  <= '0;
      fabric_kind <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        fmrc_pkg::REG_RULE_COUNT:  rule_count  <= pwdata[fmrc_pkg::CNT_W-1:0];
        fmrc_pkg::REG_FABRIC_KIND: fabric_kind <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      fmrc_pkg::REG_RULE_COUNT:  prdata = 32'(rule_count);
      fmrc_pkg::REG_FABRIC_KIND: prdata = 32'(fabric_kind);
    endcase
  end

  // ---------------- command intake ----------------
  assign accept  = start && !busy;
  assign wr_en   = accept && (opcode == fmrc_pkg::OP_WRITE);
  assign eval_en = accept && (opcode == fmrc_pkg::OP_EVAL);

  always_comb begin
    wr_rule.pred.peer        = peer_value;
    wr_rule.pred.size        = size_value;
    wr_rule.pred.freq        = freq_value;
    wr_rule.mask             = test_mask;
    wr_rule.dec.path         = path_in;
    wr_rule.dec.slots        = slot_depth_in;
    wr_rule.dec.pool         = pool_size_in;
    wr_rule.dec.chmap        = channel_map_in;
    wr_rule.dec.conservative = conservative_in;
    wr_rule.dec.rule_id      = rule_id_in;
  end

  // head of chain: a fresh lookup with nothing found yet
  always_comb begin
    chain[0].valid    = eval_en;
    chain[0].key.peer = peer_value;
    chain[0].key.size = size_value;
    chain[0].key.freq = freq_value;
    chain[0].found    = 1'b0;
    chain[0].dec      = '0;
  end

  // busy covers one lookup from accept until its result leaves the chain
  always_comb begin
    busy_next = busy;
    if (eval_en) begin
      busy_next = 1'b1;
    end else if (tail.valid) begin
      busy_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= busy_next;
    end
  end

  // ---------------- cell chain ----------------
  for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
    fmrc_cell #(
      .INDEX       (i),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .wr_en      (wr_en),
      .wr_index   (entry_index),
      .wr_rule    (wr_rule),
      .rule_count (rule_count),
      .tok_in     (chain[i]),
      .tok_out    (chain[i+1])
    );
  end

  assign tail = chain[MAX_RULES];

  // ---------------- result registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tail.valid) begin
      if (tail.found) begin
        path_out         <= tail.dec.path;
        slot_depth_out   <= tail.dec.slots;
        pool_size_out    <= tail.dec.pool;
        channel_map_out  <= tail.dec.chmap;
        conservative_out <= tail.dec.conservative;
        rule_id_out      <= tail.dec.rule_id;
      end else begin
        // no rule matched
        path_out         <= fabric_kind ? fmrc_pkg::PATH_PROXY : fmrc_pkg::PATH_NATIVE;
        slot_depth_out   <= '0;
        pool_size_out    <= fmrc_pkg::FALLBACK_POOL;
        channel_map_out  <= 1'b0;
        conservative_out <= 1'b1;
        rule_id_out      <= fmrc_pkg::FALLBACK_ID;
      end
    end
  end

endmodule
`default_nettype wire

/* tb/sv/tb_first_match_rule_classifier.sv */
// Self-checking testbench for the first-match rule classifier: rule writes, lookups, fallback.
`timescale 1ns / 100ps
module tb_first_match_rule_classifier;

  localparam int MAX_RULES   = fmrc_pkg::MAX_RULES_DEF;
  // Settling wait, longer than a whole lookup.
  localparam int SETTLE      = MAX_RULES + 4;
  // No handshake of any kind for this many cycles means the block is hung.
  localparam int STALL_LIMIT = 1000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 205;

  // One command as the sender sees it: opcode, target entry and the rule fields.
  // On a lookup, rule.pred carries the three feature classes.
  typedef struct packed {
    logic            op;
    logic [5:0]      idx;
    fmrc_pkg::rule_t rule;
  } cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Command port, all driven to known values from time zero
  logic        start           = 1'b0;
  logic        opcode          = fmrc_pkg::OP_WRITE;
  logic [5:0]  entry_index     = '0;
  logic [1:0]  peer_value      = '0;
  logic [1:0]  size_value      = '0;
  logic [1:0]  freq_value      = '0;
  logic [2:0]  test_mask       = '0;
  logic [1:0]  path_in         = '0;
  logic [15:0] slot_depth_in   = '0;
  logic [15:0] pool_size_in    = '0;
  logic        channel_map_in  = 1'b0;
  logic        conservative_in = 1'b0;
  logic [15:0] rule_id_in      = '0;

  // Register port
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;

  // Outputs
  logic        busy;
  logic        done;
  logic [1:0]  path_out;
  logic [15:0] slot_depth_out;
  logic [15:0] pool_size_out;
  logic        channel_map_out;
  logic        conservative_out;
  logic [15:0] rule_id_out;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the block's state, updated at the edge where it changes in the DUT
  fmrc_pkg::rule_t     rule_tab [MAX_RULES];
  logic [6:0]          active_rules = '0;
  logic                fabric_other = 1'b0;

  // Decisions predicted for accepted lookups, oldest first (ring of 64)
  fmrc_pkg::decision_t pend_tab [0:63];
  logic [5:0]          pend_wr = '0;
  logic [5:0]          pend_rd = '0;
  fmrc_pkg::decision_t want;
  int                  errors       = 0;
  int                  stall_cycles = 0;

  always #1 clk = ~clk;

  first_match_rule_classifier uut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .opcode           (opcode),
    .entry_index      (entry_index),
    .peer_value       (peer_value),
    .size_value       (size_value),
    .freq_value       (freq_value),
    .test_mask        (test_mask),
    .path_in          (path_in),
    .slot_depth_in    (slot_depth_in),
    .pool_size_in     (pool_size_in),
    .channel_map_in   (channel_map_in),
    .conservative_in  (conservative_in),
    .rule_id_in       (rule_id_in),
    .done             (done),
    .path_out         (path_out),
    .slot_depth_out   (slot_depth_out),
    .pool_size_out    (pool_size_out),
    .channel_map_out  (channel_map_out),
    .conservative_out (conservative_out),
    .rule_id_out      (rule_id_out),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // ---------------------------------------------------------------------------
  // Predictor: first active rule whose three predicates all hold wins.
  // A predicate holds when absent, when the feature is its class's dynamic
  // code, or when it equals the feature. Peer code 3 is not dynamic.
  // rule_count past the table size covers the whole table.
  // ---------------------------------------------------------------------------
  function automatic fmrc_pkg::decision_t classify(input fmrc_pkg::key_t feat);
    fmrc_pkg::decision_t d;
    int                  n;
    int                  i;
    logic                hit;
    d.path         = fabric_other ? fmrc_pkg::PATH_PROXY : fmrc_pkg::PATH_NATIVE;
    d.slots        = '0;
    d.pool         = fmrc_pkg::FALLBACK_POOL;
    d.chmap        = 1'b0;
    d.conservative = 1'b1;
    d.rule_id      = fmrc_pkg::FALLBACK_ID;
    hit = 1'b0;
    n = (active_rules > MAX_RULES) ? MAX_RULES : int'(active_rules);
    for (i = 0; i < n; i++) begin
      if (!hit &&
          (!rule_tab[i].mask[0] || feat.peer == fmrc_pkg::PEER_DYN ||
           feat.peer == rule_tab[i].pred.peer) &&
          (!rule_tab[i].mask[1] || feat.size == fmrc_pkg::SIZE_DYN ||
           feat.size == rule_tab[i].pred.size) &&
          (!rule_tab[i].mask[2] || feat.freq == fmrc_pkg::FREQ_DYN ||
           feat.freq == rule_tab[i].pred.freq))
      begin
        d   = rule_tab[i].dec;
        hit = 1'b1;
      end
    end
    return d;
  endfunction

  // Fully random command; callers overwrite what they care about.
  function automatic cmd_t rand_cmd();
    cmd_t        c;
    logic [63:0] r;
    r      = {$urandom, $urandom};
    c.op   = 1'($urandom_range(0, 1));
    c.idx  = 6'($urandom);
    c.rule = r[$bits(fmrc_pkg::rule_t)-1:0];
    return c;
  endfunction

  function automatic cmd_t lookup_cmd(input logic [1:0] peer, input logic [1:0] size,
                                      input logic [1:0] freq);
    cmd_t c;
    c = rand_cmd();
    c.op             = fmrc_pkg::OP_EVAL;
    c.rule.pred.peer = peer;
    c.rule.pred.size = size;
    c.rule.pred.freq = freq;
    return c;
  endfunction

  function automatic cmd_t rule_cmd(input logic [5:0] idx, input logic [2:0] mask,
                                    input logic [1:0] peer, input logic [1:0] size,
                                    input logic [1:0] freq, input logic [1:0] path,
                                    input logic [15:0] slot, input logic [15:0] pool,
                                    input logic ch, input logic cons, input logic [15:0] id);
    cmd_t c;
    c.op                    = fmrc_pkg::OP_WRITE;
    c.idx                   = idx;
    c.rule.pred.peer        = peer;
    c.rule.pred.size        = size;
    c.rule.pred.freq        = freq;
    c.rule.mask             = mask;
    c.rule.dec.path         = path;
    c.rule.dec.slots        = slot;
    c.rule.dec.pool         = pool;
    c.rule.dec.chmap        = ch;
    c.rule.dec.conservative = cons;
    c.rule.dec.rule_id      = id;
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Called at a rising edge; presents the item and holds start until
  // the edge where busy is low. Start is left high on return so back-to-back
  // items need no second assignment in the same step; a gap from pause()
  // or drain() lowers it. The shadow state and the expectation are updated at the
  // accepting edge, which keeps them in the DUT's order.
  // ---------------------------------------------------------------------------
  task automatic send_command(input cmd_t c);
    opcode          <= c.op;
    entry_index     <= c.idx;
    peer_value      <= c.rule.pred.peer;
    size_value      <= c.rule.pred.size;
    freq_value      <= c.rule.pred.freq;
    test_mask       <= c.rule.mask;
    path_in         <= c.rule.dec.path;
    slot_depth_in   <= c.rule.dec.slots;
    pool_size_in    <= c.rule.dec.pool;
    channel_map_in  <= c.rule.dec.chmap;
    conservative_in <= c.rule.dec.conservative;
    rule_id_in      <= c.rule.dec.rule_id;
    start           <= 1'b1;
    do @(posedge clk); while (busy);
    if (c.op == fmrc_pkg::OP_WRITE) begin
      rule_tab[c.idx] = c.rule;
    end else begin
      pend_tab[pend_wr] = classify(c.rule.pred);
      pend_wr = pend_wr + 6'd1;
    end
  endtask

  // Random gap after an item: mostly none or short, now and then longer than
  // a whole lookup so start rises at every point of the chain walk.
  task automatic pause(input bit quiet);
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (quiet || r < 55)  n = 0;
    else if (r < 85)      n = $urandom_range(1, 3);
    else if (r < 97)      n = $urandom_range(4, 12);
    else                  n = $urandom_range(20, 70);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Wait for every lookup to come back, then for the SETTLE wait so a
  // trailing rule write has surely landed.
  task automatic drain();
    start <= 1'b0;
    while (pend_rd != pend_wr) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write: setup, access, then idle. Upper pwdata
  // bits are random since the register only keeps its low bits.
  task automatic set_reg(input logic sel, input int unsigned value);
    logic [31:0] data;
    data = $urandom;
    if (sel == fmrc_pkg::REG_RULE_COUNT) data[6:0] = value[6:0];
    else                                 data[0]   = value[0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (sel == fmrc_pkg::REG_RULE_COUNT) active_rules = data[6:0];
    else                                 fabric_other = data[0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty active set: every lookup falls back; fabric_kind picks the path.
  task automatic test_fallback();
    drain();
    set_reg(fmrc_pkg::REG_RULE_COUNT, 0);
    set_reg(fmrc_pkg::REG_FABRIC_KIND, 0);
    send_command(lookup_cmd(2'd0, 2'd0, 2'd0));
    pause(1'b0);
    drain();
    set_reg(fmrc_pkg::REG_FABRIC_KIND, 1);
    send_command(lookup_cmd(2'd3, 2'd3, 2'd3));
    pause(1'b0);
    send_command(lookup_cmd(fmrc_pkg::PEER_DYN, 2'd1, 2'd2));
    pause(1'b0);
  endtask

  // Hand-built table where each lookup should land on a known entry:
  // single-predicate rules, a full-mask rule, a catch-all at the end,
  // dynamic features, unused peer code 3 and unused path code 3, field extremes.
  task automatic test_first_match();
    send_command(rule_cmd(6'd0, 3'b111, 2'd1, 2'd2, 2'd1, 2'd3, 16'hFFFF, 16'h0000,
                          1'b1, 1'b0, 16'h7FFF));
    pause(1'b0);
    send_command(rule_cmd(6'd1, 3'b001, 2'd3, 2'd0, 2'd0, 2'd1, 16'h0000, 16'hFFFF,
                          1'b0, 1'b1, 16'h8000));
    pause(1'b0);
    send_command(rule_cmd(6'd2, 3'b010, 2'd0, 2'd0, 2'd3, 2'd2, 16'h1234, 16'h8001,
                          1'b1, 1'b1, 16'hFFFF));
    pause(1'b0);
    send_command(rule_cmd(6'd3, 3'b100, 2'd1, 2'd1, 2'd2, 2'd0, 16'h00FF, 16'h0010,
                          1'b0, 1'b0, 16'h0000));
    pause(1'b0);
    send_command(rule_cmd(6'd4, 3'b110, 2'd2, 2'd1, 2'd0, 2'd1, 16'hA5A5, 16'h5A5A,
                          1'b1, 1'b0, 16'h0005));
    pause(1'b0);
    send_command(rule_cmd(6'd5, 3'b000, 2'd3, 2'd3, 2'd3, 2'd2, 16'h8000, 16'h7FFF,
                          1'b0, 1'b1, 16'h1234));
    drain();
    set_reg(fmrc_pkg::REG_RULE_COUNT, 6);
    set_reg(fmrc_pkg::REG_FABRIC_KIND, 0);
    send_command(lookup_cmd(2'd1, 2'd2, 2'd1));     // exact hit on the full-mask rule
    pause(1'b0);
    send_command(lookup_cmd(2'd3, 2'd0, 2'd0));     // peer 3 is literal, hits entry 1
    pause(1'b0);
    send_command(lookup_cmd(fmrc_pkg::PEER_DYN, 2'd2, 2'd1)); // dynamic peer passes entry 0
    pause(1'b0);
    send_command(lookup_cmd(2'd0, 2'd0, fmrc_pkg::FREQ_DYN)); // size-only rule
    pause(1'b0);
    send_command(lookup_cmd(2'd0, 2'd1, 2'd2));     // freq-only rule
    pause(1'b0);
    send_command(lookup_cmd(2'd0, 2'd1, 2'd0));     // two-predicate rule
    pause(1'b0);
    send_command(lookup_cmd(2'd0, 2'd2, 2'd0));     // only the catch-all is left
    pause(1'b0);
    drain();
    // Same lookup with the catch-all outside the active set: fallback
    set_reg(fmrc_pkg::REG_RULE_COUNT, 5);
    send_command(lookup_cmd(2'd0, 2'd2, 2'd0));
    pause(1'b0);
  endtask

  // Write every entry back to back so that any rule_count is legal afterwards.
  task automatic test_fill_table();
    cmd_t c;
    int   i;
    for (i = 0; i < MAX_RULES; i++) begin
      c = rand_cmd();
      c.op  = fmrc_pkg::OP_WRITE;
      c.idx = 6'(i);
      send_command(c);
      pause(1'b1);
    end
  endtask

  // Mixed rule writes and lookups over several register settings, including
  // an empty active set, a single rule, the full table and counts past it.
  // Strict phases set most predicate bits so hits land deep in the table or
  // fall through; loose phases hit early.
  task automatic test_random_traffic();
    cmd_t        c;
    int          ph;
    int          k;
    int unsigned cnt;
    int unsigned eff;
    int          strict;
    int          wr_pct;
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin cnt = 64;  strict = 90; wr_pct = 30; end
        1:       begin cnt = 1;   strict = 50; wr_pct = 40; end
        2:       begin cnt = 127; strict = 95; wr_pct = 25; end
        3:       begin cnt = 17;  strict = 90; wr_pct = 30; end
        4:       begin cnt = 0;   strict = 50; wr_pct = 20; end
        5:       begin cnt = 64;  strict = 60; wr_pct = 10; end
        6:       begin cnt = 100; strict = 85; wr_pct = 35; end
        default: begin cnt = 63;  strict = 75; wr_pct = 30; end
      endcase
      eff = (cnt > MAX_RULES) ? MAX_RULES : cnt;
      drain();
      set_reg(fmrc_pkg::REG_RULE_COUNT, cnt);
      set_reg(fmrc_pkg::REG_FABRIC_KIND, ph % 2);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        c = rand_cmd();
        c.op = ($urandom_range(0, 99) < wr_pct) ? fmrc_pkg::OP_WRITE : fmrc_pkg::OP_EVAL;
        c.rule.mask = {$urandom_range(0, 99) < strict, $urandom_range(0, 99) < strict,
                       $urandom_range(0, 99) < strict};
        // Half the rewrites are aimed at the active part so the winner keeps moving
        if (c.op == fmrc_pkg::OP_WRITE && eff != 0 && $urandom_range(0, 1) == 1)
          c.idx = 6'($urandom_range(0, eff - 1));
        send_command(c);
        pause(ph == 3);   // one phase runs without gaps
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every done cycle must match the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic cmp(input string what, input logic [15:0] exp_v, input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pend_rd == pend_wr) begin
        errors++;
        $display("%0t: result with nothing pending, expected none, actual rule_id %0d",
                 $time, $signed(rule_id_out));
      end else begin
        want = pend_tab[pend_rd];
        pend_rd = pend_rd + 6'd1;
        cmp("path_out",         16'(want.path),         16'(path_out));
        cmp("slot_depth_out",   want.slots,             slot_depth_out);
        cmp("pool_size_out",    want.pool,              pool_size_out);
        cmp("channel_map_out",  16'(want.chmap),        16'(channel_map_out));
        cmp("conservative_out", 16'(want.conservative), 16'(conservative_out));
        cmp("rule_id_out",      want.rule_id,           rule_id_out);
      end
    end
  end

  // Watchdog: any accepted item, result or register write resets the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable && pwrite))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_fallback();
    test_first_match();
    test_fill_table();
    test_random_traffic();
    drain();
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* sim.f */
design/fmrc_pkg.sv
design/fmrc_cell.sv
design/first_match_rule_classifier.sv
tb/sv/tb_first_match_rule_classifier.sv
